// ----- sv/fiq_pkg.sv -----
// Shared types and constants for the fixed-integrand quadrature unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package fiq_pkg;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
    localparam logic [OP_W-1:0] OP_HDIV = 4'd2;
    localparam logic [OP_W-1:0] OP_INIT = 4'd3;
    localparam logic [OP_W-1:0] OP_X2   = 4'd4;
    localparam logic [OP_W-1:0] OP_X3   = 4'd5;
    localparam logic [OP_W-1:0] OP_ROOT = 4'd6;
    localparam logic [OP_W-1:0] OP_F    = 4'd7;
    localparam logic [OP_W-1:0] OP_ACC  = 4'd8;
    localparam logic [OP_W-1:0] OP_PART = 4'd9;
    localparam logic [OP_W-1:0] OP_QDIV = 4'd10;
    localparam logic [OP_W-1:0] OP_RES  = 4'd11;

    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_TRAP  = 2'd2;
    localparam logic [1:0] MODE_SIMP  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_ODD  = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;

    localparam logic [30:0] UPPER_RESET = 31'h4000_0000;
    localparam logic [63:0] SAT_POS = 64'h0000_007F_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h0000_0080_0000_0000;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [4:0]      arg;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic last_point;
        logic div_busy;
    } stat_t;

endpackage
`default_nettype wire

// ----- sv/fiq_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Used by the datapath for the step width and the final rule divisor.
`default_nettype none
module fiq_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [17:0] trial;
    logic [17:0] diff;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, num_reg[63]};
        diff      = trial - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[16:0];
                num_next = {num_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[16:0];
                num_next = {num_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;
endmodule
`default_nettype wire

// ----- sv/fiq_datapath.sv -----
// Datapath: sample point, integrand with shared 32x32 multiplier and
// bit-by-bit root, weighted sum, final product and result register.
// Depends on fiq_pkg and fiq_div.
`default_nettype none
module fiq_datapath #(
    parameter int MAX_INTERVALS = 65536
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire fiq_pkg::cmd_t cmd,
    output fiq_pkg::stat_t     stat,
    input  wire logic [16:0]   n_in,
    input  wire logic [1:0]    mode_in,
    input  wire logic [30:0]   lower_in,
    input  wire logic [30:0]   upper_in,
    output logic [39:0]        res_value,
    output logic [1:0]         res_code
);
    localparam logic [24:0] MAX_N = 25'(MAX_INTERVALS);

    logic [16:0]  n_reg, k_reg;
    logic [1:0]   mode_reg, code_reg;
    logic [30:0]  a_reg, b_reg, x_reg;
    logic         neg_reg;
    logic [46:0]  hm_reg;
    logic [47:0]  pos_reg;
    logic [63:0]  sum_reg;
    logic [31:0]  x2_reg, root_reg;
    logic [32:0]  x3_reg;
    logic [33:0]  f_reg;
    logic [111:0] acc_reg;
    logic [39:0]  val_reg;
    logic [1:0]   rcode_reg;

    logic [16:0]  n_clamp;
    logic [30:0]  x_sel, mag;
    logic [31:0]  opa, opb, trial;
    logic [63:0]  mul_p, v, wf, q_clamp, div_num;
    logic [33:0]  x3p;
    logic [16:0]  div_den;
    logic         div_start, div_busy, last;
    logic [63:0]  quot;
    logic [2:0]   w;

    assign n_clamp = ({8'd0, n_in} > MAX_N) ? MAX_N[16:0] : n_in;
    assign last    = (k_reg == n_reg);
    assign x_sel   = last ? b_reg : pos_reg[46:16];
    assign trial   = root_reg | (32'd1 << cmd.arg);
    assign x3p     = {1'b0, x3_reg} + 34'h0_4000_0000;
    assign v       = {x3p, 30'd0};
    assign mag     = neg_reg ? (a_reg - b_reg) : (b_reg - a_reg);
    assign mul_p   = 64'(opa) * 64'(opb);

    always_comb begin
        opa = '0;
        opb = '0;
        case (cmd.op)
            fiq_pkg::OP_X2: begin
                opa = {1'b0, x_sel};
                opb = {1'b0, x_sel};
            end
            fiq_pkg::OP_X3: begin
                opa = x2_reg;
                opb = {1'b0, x_reg};
            end
            fiq_pkg::OP_ROOT: begin
                opa = trial;
                opb = trial;
            end
            fiq_pkg::OP_F: begin
                opa = x2_reg;
                opb = root_reg;
            end
            fiq_pkg::OP_PART: begin
                opa = cmd.arg[1] ? sum_reg[63:32] : sum_reg[31:0];
                opb = cmd.arg[0] ? {17'd0, hm_reg[46:32]} : hm_reg[31:0];
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb begin
        case (mode_reg)
            fiq_pkg::MODE_LEFT:  w = last ? 3'd0 : 3'd1;
            fiq_pkg::MODE_RIGHT: w = (k_reg == '0) ? 3'd0 : 3'd1;
            fiq_pkg::MODE_TRAP:  w = (last || k_reg == '0) ? 3'd1 : 3'd2;
            default:             w = (last || k_reg == '0) ? 3'd1 :
                                     (k_reg[0] ? 3'd4 : 3'd2);
        endcase
        case (w)
            3'd1:    wf = {30'd0, f_reg};
            3'd2:    wf = {29'd0, f_reg, 1'b0};
            3'd4:    wf = {28'd0, f_reg, 2'b0};
            default: wf = '0;
        endcase
    end

    assign div_start = (cmd.op == fiq_pkg::OP_HDIV) || (cmd.op == fiq_pkg::OP_QDIV);
    assign div_num   = (cmd.op == fiq_pkg::OP_HDIV) ? {17'd0, mag, 16'd0}
                                                    : acc_reg[107:44];
    assign div_den   = (cmd.op == fiq_pkg::OP_HDIV) ? n_reg :
                       (mode_reg == fiq_pkg::MODE_TRAP) ? 17'd2 :
                       (mode_reg == fiq_pkg::MODE_SIMP) ? 17'd3 : 17'd1;

    fiq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb begin
        if (neg_reg) begin
            q_clamp = (quot > fiq_pkg::SAT_NEG) ? fiq_pkg::SAT_NEG : quot;
        end else begin
            q_clamp = (quot > fiq_pkg::SAT_POS) ? fiq_pkg::SAT_POS : quot;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            fiq_pkg::OP_LOAD: begin
                n_reg    <= n_clamp;
                mode_reg <= mode_in;
                a_reg    <= lower_in;
                b_reg    <= upper_in;
                neg_reg  <= (upper_in < lower_in);
                if (n_clamp == '0) begin
                    code_reg <= fiq_pkg::ST_ZERO;
                end else if (mode_in == fiq_pkg::MODE_SIMP && n_clamp[0]) begin
                    code_reg <= fiq_pkg::ST_ODD;
                end else begin
                    code_reg <= fiq_pkg::ST_OK;
                end
            end
            fiq_pkg::OP_INIT: begin
                hm_reg  <= quot[46:0];
                pos_reg <= {1'b0, a_reg, 16'd0};
                k_reg   <= '0;
                sum_reg <= '0;
            end
            fiq_pkg::OP_X2: begin
                x_reg  <= x_sel;
                x2_reg <= mul_p[61:30];
            end
            fiq_pkg::OP_X3: begin
                x3_reg   <= mul_p[62:30];
                root_reg <= '0;
            end
            fiq_pkg::OP_ROOT: begin
                if (mul_p <= v) begin
                    root_reg <= trial;
                end
            end
            fiq_pkg::OP_F: begin
                f_reg <= mul_p[63:30];
            end
            fiq_pkg::OP_ACC: begin
                sum_reg <= sum_reg + wf;
                if (!last) begin
                    k_reg   <= k_reg + 17'd1;
                    pos_reg <= neg_reg ? (pos_reg - {1'b0, hm_reg})
                                       : (pos_reg + {1'b0, hm_reg});
                end
            end
            fiq_pkg::OP_PART: begin
                case (cmd.arg[1:0])
                    2'd0:    acc_reg <= {48'd0, mul_p};
                    2'd3:    acc_reg <= acc_reg + {mul_p[47:0], 64'd0};
                    default: acc_reg <= acc_reg + {16'd0, mul_p, 32'd0};
                endcase
            end
            fiq_pkg::OP_RES: begin
                rcode_reg <= code_reg;
                if (code_reg != fiq_pkg::ST_OK) begin
                    val_reg <= '0;
                end else if (neg_reg) begin
                    val_reg <= 40'(64'd0 - q_clamp);
                end else begin
                    val_reg <= q_clamp[39:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.err        = (code_reg != fiq_pkg::ST_OK);
    assign stat.last_point = last;
    assign stat.div_busy   = div_busy;
    assign res_value       = val_reg;
    assign res_code        = rcode_reg;
endmodule
`default_nettype wire

// ----- sv/fiq_ctrl.sv -----
// Controller state machine: sequences load, step division, the per-point
// integrand evaluation, the final product and division, and the result.
// Depends on fiq_pkg.
`default_nettype none
module fiq_ctrl #(
    parameter int ROOT_ITERATIONS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output fiq_pkg::cmd_t       cmd,
    input  wire fiq_pkg::stat_t stat
);
    localparam int ROOT_STEPS = (ROOT_ITERATIONS < 32) ? ROOT_ITERATIONS : 32;
    localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_X2    = 4'd4;
    localparam logic [3:0] S_X3    = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_F     = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_PART  = 4'd9;
    localparam logic [3:0] S_QDIV  = 4'd10;
    localparam logic [3:0] S_QWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        cmd.op     = fiq_pkg::OP_NOP;
        cmd.arg    = '0;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = fiq_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.err) begin
                    state_next = S_OUT;
                end else begin
                    cmd.op     = fiq_pkg::OP_HDIV;
                    state_next = S_HWAIT;
                end
            end
            S_HWAIT: begin
                if (!stat.div_busy) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.op     = fiq_pkg::OP_INIT;
                state_next = S_X2;
            end
            S_X2: begin
                cmd.op     = fiq_pkg::OP_X2;
                state_next = S_X3;
            end
            S_X3: begin
                cmd.op     = fiq_pkg::OP_X3;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                cmd.op   = fiq_pkg::OP_ROOT;
                cmd.arg  = 5'd31 - cnt_reg;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == ROOT_LAST) begin
                    state_next = S_F;
                end
            end
            S_F: begin
                cmd.op     = fiq_pkg::OP_F;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op   = fiq_pkg::OP_ACC;
                cnt_next = '0;
                state_next = stat.last_point ? S_PART : S_X2;
            end
            S_PART: begin
                cmd.op   = fiq_pkg::OP_PART;
                cmd.arg  = cnt_reg;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3) begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV: begin
                cmd.op     = fiq_pkg::OP_QDIV;
                state_next = S_QWAIT;
            end
            S_QWAIT: begin
                if (!stat.div_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!valid_reg || m_tready) begin
                    cmd.op     = fiq_pkg::OP_RES;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;
endmodule
`default_nettype wire

// ----- sv/fixed_integrand_quadrature_unit.sv -----
// Fixed-integrand quadrature unit: integrates x^2*sqrt(1+x^3) between two
// configured limits with a selectable rule. Each request on the slave
// channel carries an interval count n; one result request leaves on the
// master channel with the Q8.32 integral and a status code.
// Configuration (rule, lower and upper limit) is to be written through cfg_*
// only while the unit is idle; the block itself does not enforce this. One
// item is worked at a time. A zero count or an odd count under Simpson skips
// the integration and yields a zero value with its status code. Otherwise
// each of the n+1 sample points is worked in turn as the square, the cube,
// R root bits (R is ROOT_ITERATIONS capped at 32), the product and the sum,
// and the step width and the final rule divisor each come from the serial
// divider. The result is held in an output register; the next request is
// accepted while it waits, and a stalled receiver only delays the following
// result. Reset (aresetn low, synchronous) clears the sequencer and the
// output valid and sets the rule to left rectangle and the limits to 0.0
// and 1.0.
`default_nettype none
module fixed_integrand_quadrature_unit #(
    parameter int MAX_INTERVALS   = 65536,
    parameter int ROOT_ITERATIONS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [16:0] interval_count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [39:0] integral_value, [41:40] status_code
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [30:0] cfg_wdata
);
    logic [1:0]     mode_reg;
    logic [30:0]    lower_reg, upper_reg;
    fiq_pkg::cmd_t  cmd;
    fiq_pkg::stat_t stat;
    logic [39:0]    res_value;
    logic [1:0]     res_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= fiq_pkg::MODE_LEFT;
            lower_reg <= '0;
            upper_reg <= fiq_pkg::UPPER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fiq_pkg::REG_MODE:  mode_reg  <= cfg_wdata[1:0];
                fiq_pkg::REG_LOWER: lower_reg <= cfg_wdata;
                fiq_pkg::REG_UPPER: upper_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fiq_ctrl #(
        .ROOT_ITERATIONS (ROOT_ITERATIONS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fiq_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .n_in      (s_tdata[16:0]),
        .mode_in   (mode_reg),
        .lower_in  (lower_reg),
        .upper_in  (upper_reg),
        .res_value (res_value),
        .res_code  (res_code)
    );

    assign m_tdata = {6'd0, res_code, res_value};

    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == fiq_pkg::OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("load issued without an accepted request");

    a_idle_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !stat.div_busy)
        else $error("divider busy while accepting");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[41:40] != fiq_pkg::ST_OK) |-> (m_tdata[39:0] == 40'd0))
        else $error("error result carries a nonzero value");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == fiq_pkg::OP_RES) |-> (!m_tvalid || m_tready))
        else $error("result overwritten while stalled");
endmodule
`default_nettype wire
